// File: hw/rtl/cnms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_pkg
// types and constants shared by the cross neighbour suppression files
// ----------------------------------------------------------------------------
package cnms_pkg;

  localparam int PIX_W      = 32;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int MIN_SIZE   = 3;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

  // register select, word address bit
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_value;
  } cnms_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] out_value;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    last_of_frame;
  } cnms_out_t;

endpackage

// File: hw/rtl/cnms_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_chan_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface cnms_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/cross_neighbour_non_max_suppression_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_neighbour_non_max_suppression_top
// four-neighbour non-maximum suppression over a raster pixel stream
// ----------------------------------------------------------------------------
// a result passes through the compare stage and then the output register
// before it is on out_chan; one item per cycle while out_chan is ready; a
//   last-row item holds the input until its two results pass the output register
// the row stores are two synchronous rams, read on accept, written back when
//   the item leaves the compare stage; reset clears control state only and
//   the stores hold nothing defined until a frame has written them
module cross_neighbour_non_max_suppression_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cnms_chan_if.sink                    in_chan,
  cnms_chan_if.source                  out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cnms_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [SIZE_W-1:0] cfg_width_r, cfg_height_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_WIDTH;
      cfg_height_r <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  cfg_width_r  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(cfg_width_r);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg_height_r);
      default: prdata = '0;
    endcase
  end

  // sizes clamped to the legal range
  logic [CW-1:0]     w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_comb begin
    if (cfg_width_r < SIZE_W'(MIN_SIZE))        w_eff = CW'(MIN_SIZE);
    else if (32'(cfg_width_r) > MAX_WIDTH)      w_eff = CW'(MAX_WIDTH);
    else                                        w_eff = CW'(cfg_width_r);
    if (cfg_height_r < SIZE_W'(MIN_SIZE))       h_eff = SIZE_W'(MIN_SIZE);
    else if (32'(cfg_height_r) > MAX_HEIGHT)    h_eff = SIZE_W'(MAX_HEIGHT);
    else                                        h_eff = cfg_height_r;
  end

  // position of the next item
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    cur_c;
  logic [ROW_W-1:0] cur_r;
  logic             restart, last_col, last_row, has_mid, border;
  logic [AW-1:0]    addr_c, addr_right;
  logic             in_fire;

  always_comb begin
    restart  = (col_r >= w_eff) || ({1'b0, row_r} >= h_eff);
    cur_c    = restart ? '0 : col_r;
    cur_r    = restart ? '0 : row_r;
    last_col = (cur_c == w_eff - CW'(1));
    last_row = ({1'b0, cur_r} == h_eff - SIZE_W'(1));
    has_mid  = (cur_r != '0);
    border   = (cur_r == ROW_W'(1)) || (cur_c == '0) || last_col;
    addr_c     = cur_c[AW-1:0];
    addr_right = last_col ? '0 : AW'(cur_c + CW'(1));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : cur_r + ROW_W'(1);
    end else begin
      col_nxt = cur_c + CW'(1);
      row_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // row stores
  logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
  logic [PIX_W-1:0] sec_mem  [MAX_WIDTH];
  logic signed [PIX_W-1:0] up_r, mid_r, right_r, left_r;

  // compare stage
  logic                    s1_v_r, s1_v_nxt;
  logic signed [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]           s1_col_r;
  logic [ROW_W-1:0]        s1_row_r;
  logic                    s1_has_mid_r, s1_border_r, s1_last_row_r, s1_last_col_r;
  logic                    phase_r, phase_nxt;
  logic                    s1_none, s1_both, emit_slot, s1_emit, s1_done;
  logic                    suppress;
  cnms_out_t               res;

  // output register
  logic      ov_r, ov_nxt;
  cnms_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      up_r    <= sec_mem[addr_c];
      mid_r   <= prev_mem[addr_c];
      right_r <= prev_mem[addr_right];
    end
    if (s1_done) begin
      sec_mem[s1_col_r[AW-1:0]]  <= mid_r;
      prev_mem[s1_col_r[AW-1:0]] <= s1_pix_r;
    end
  end

  always_comb begin
    s1_none   = !s1_has_mid_r && !s1_last_row_r;
    s1_both   = s1_has_mid_r && s1_last_row_r;
    emit_slot = !ov_r || out_chan.ready;
    s1_emit   = s1_v_r && !s1_none && emit_slot;
    s1_done   = s1_v_r && (s1_none || (emit_slot && (phase_r || !s1_both)));
    in_fire   = in_chan.valid && in_chan.ready;
    s1_v_nxt  = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_v_r);
    phase_nxt = s1_done ? 1'b0 : ((s1_emit && s1_both) ? 1'b1 : phase_r);
    ov_nxt    = s1_emit ? 1'b1 : (out_chan.ready ? 1'b0 : ov_r);

    suppress = (up_r >= mid_r) || (left_r >= mid_r) ||
               (right_r >= mid_r) || (s1_pix_r >= mid_r);

    // the pixel above goes first, the item itself follows on the last row
    if (s1_has_mid_r && !phase_r) begin
      res.out_value     = (!s1_border_r && suppress) ? '0 : mid_r;
      res.out_row       = s1_row_r - ROW_W'(1);
      res.out_col       = COL_W'(s1_col_r);
      res.last_of_frame = 1'b0;
    end else begin
      res.out_value     = s1_pix_r;
      res.out_row       = s1_row_r;
      res.out_col       = COL_W'(s1_col_r);
      res.last_of_frame = s1_last_col_r;
    end
  end

  assign in_chan.ready  = !s1_v_r || s1_done;
  assign out_chan.valid = ov_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      phase_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r      <= in_chan.data.pixel_value;
      s1_col_r      <= cur_c;
      s1_row_r      <= cur_r;
      s1_has_mid_r  <= has_mid;
      s1_border_r   <= border;
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
    end
    // left neighbour is the centre of the item before
    if (s1_done) begin
      left_r <= mid_r;
    end
    if (s1_emit) begin
      out_data_r <= res;
    end
  end

  // the write-back never lands on an entry read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_done) |->
      (s1_col_r[AW-1:0] != addr_c) && (s1_col_r[AW-1:0] != addr_right))
    else $error("row store write collides with a read");

  // second result only for an item that has two
  a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (s1_v_r && s1_has_mid_r && s1_last_row_r))
    else $error("second result phase without a last-row item");

  // a last-row item with a pixel above may not leave before its first result
  a_both_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_done && s1_both) |-> phase_r)
    else $error("last-row item left with a result missing");

  // a new item never overwrites an item still in the compare stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_v_r) |-> s1_done)
    else $error("compare stage overwritten");

endmodule
